// ===== sv/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell line tokenizer package
// Result record, result kinds, token types, error causes and byte classes.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [1:0] TYPE_WORD    = 2'd0;
    localparam logic [1:0] TYPE_LITERAL = 2'd1;
    localparam logic [1:0] TYPE_DQUOTE  = 2'd2;
    localparam logic [1:0] TYPE_SQUOTE  = 2'd3;

    localparam logic [1:0] CAUSE_BAD_START = 2'd0;
    localparam logic [1:0] CAUSE_NONPRINT  = 2'd1;
    localparam logic [1:0] CAUSE_UNTERM    = 2'd2;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [15:0] CONS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  token_type;
        logic [7:0]  out_byte;
        logic [1:0]  error_cause;
        logic        ok;
        logic [15:0] consumed;
        logic        last;
    } result_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_graph(input logic [7:0] b);
        return (b >= 8'h21) && (b <= 8'h7E);
    endfunction

    function automatic logic is_print(input logic [7:0] b);
        return (b >= 8'h20) && (b <= 8'h7E);
    endfunction

    function automatic result_t res_byte(input logic [1:0] t, input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = KIND_BYTE;
        r.token_type = t;
        r.out_byte = b;
        return r;
    endfunction

    function automatic result_t res_end(input logic [1:0] t);
        result_t r;
        r = '0;
        r.kind = KIND_END;
        r.token_type = t;
        return r;
    endfunction

    function automatic result_t res_err(input logic [1:0] c);
        result_t r;
        r = '0;
        r.kind = KIND_ERR;
        r.error_cause = c;
        return r;
    endfunction

    function automatic result_t res_done(input logic ok, input logic [15:0] cons);
        result_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.ok = ok;
        r.consumed = cons;
        return r;
    endfunction

endpackage

// ===== sv/shell_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Shell line tokenizer
// Splits a command-line byte stream into words, literals and quoted tokens.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transfer in s_axis_tdata; s_axis_tuser high
// marks end of text (no byte). Result stream: token bytes (tuser kind 0),
// end-of-token markers (1), errors (2) and a final status with byte count (3).
// m_axis_tlast is high on the last result caused by one input transfer.
// Each accepted byte is classified in the cycle it arrives and its zero to
// three results land in a four-entry result queue; the first can appear on
// m_axis_tvalid in the cycle after acceptance. One byte per cycle is sustained
// while the receiver takes one result per cycle; a byte that yields two or
// three results (high-byte pairs, token end plus error) needs a transfer on
// the output for each, and s_axis_tready drops while fewer than three queue
// entries are free. Configuration writes (cfg_wr_en) take effect at once and
// belong between texts. Synchronous reset (aresetn low) empties the queue,
// returns the parser to idle between tokens and clears both options. While the
// receiver stalls, results hold in the queue and input stops once it holds two.
// ----------------------------------------------------------------------------
module shell_line_tokenizer #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] end_of_text

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] token_type, [9:2] out_byte, [11:10] error_cause, [12] ok,
    // [28:13] consumed, [31:29] zero
    output logic [31:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic CFG_KEEP_QUOTES  = 1'b0;
    localparam logic CFG_WORD_ESCAPES = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE          = 4'd0,
        ST_START_LEAD    = 4'd1,
        ST_WORD          = 4'd2,
        ST_WORD_LEAD     = 4'd3,
        ST_WORD_ESC      = 4'd4,
        ST_WORD_ESC_LEAD = 4'd5,
        ST_DOLLAR_TRIM   = 4'd6,
        ST_QUOTE         = 4'd7,
        ST_QUOTE_ESC     = 4'd8,
        ST_FAILED        = 4'd9
    } state_t;

    logic                  keep_quotes_reg;
    logic                  word_escapes_reg;
    state_t                state_reg, state_next;
    logic                  qsingle_reg, qsingle_next;
    logic [7:0]            lead_reg, lead_next;
    logic [1:0]            type_reg, type_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    stok_pkg::result_t     q_reg [4];
    logic [1:0]            head_reg, tail_reg;
    logic [2:0]            fill_reg;

    stok_pkg::result_t     res [3];
    logic [1:0]            n_res;
    logic                  do_idle, do_word;
    logic [7:0]            b;
    logic [7:0]            qc;
    logic [CW-1:0]         count_ext;
    logic [15:0]           count_sat;
    logic                  accept, pop;
    stok_pkg::result_t     head;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (fill_reg <= 3'd1);
    assign m_axis_tvalid = (fill_reg != 3'd0);

    assign head = q_reg[head_reg];
    assign m_axis_tdata = {3'b000, head.consumed, head.ok, head.error_cause,
                           head.out_byte, head.token_type};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    assign count_ext = CW'(count_reg);
    assign count_sat = (count_ext > CW'(stok_pkg::CONS_MAX)) ? stok_pkg::CONS_MAX
                                                             : count_ext[15:0];

    always_comb begin
        state_next   = state_reg;
        qsingle_next = qsingle_reg;
        lead_next    = lead_reg;
        type_next    = type_reg;
        count_next   = count_reg;
        n_res        = 2'd0;
        res[0]       = '0;
        res[1]       = '0;
        res[2]       = '0;
        do_idle      = 1'b0;
        do_word      = 1'b0;
        b            = s_axis_tdata;
        qc           = qsingle_reg ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE;

        if (s_axis_tuser) begin
            // flush whatever token is open
            unique case (state_reg)
                ST_START_LEAD: begin
                    res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_BAD_START);
                    n_res = n_res + 2'd1;
                    state_next = ST_FAILED;
                end
                ST_WORD, ST_WORD_ESC, ST_DOLLAR_TRIM: begin
                    res[n_res] = stok_pkg::res_end(type_reg);
                    n_res = n_res + 2'd1;
                end
                ST_WORD_LEAD: begin
                    res[n_res] = stok_pkg::res_end(type_reg);
                    n_res = n_res + 2'd1;
                    res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_BAD_START);
                    n_res = n_res + 2'd1;
                    state_next = ST_FAILED;
                end
                ST_WORD_ESC_LEAD: begin
                    res[n_res] = stok_pkg::res_byte(type_reg, lead_reg);
                    n_res = n_res + 2'd1;
                    res[n_res] = stok_pkg::res_end(type_reg);
                    n_res = n_res + 2'd1;
                end
                ST_QUOTE, ST_QUOTE_ESC: begin
                    res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_UNTERM);
                    n_res = n_res + 2'd1;
                    state_next = ST_FAILED;
                end
                default: begin
                end
            endcase
            if (state_next == ST_FAILED) begin
                res[n_res] = stok_pkg::res_done(1'b0, 16'd0);
            end else begin
                res[n_res] = stok_pkg::res_done(1'b1, count_sat);
            end
            n_res = n_res + 2'd1;
            state_next   = ST_IDLE;
            qsingle_next = 1'b0;
            lead_next    = '0;
            type_next    = stok_pkg::TYPE_WORD;
            count_next   = '0;
        end else begin
            if (count_reg != '1) begin
                count_next = count_reg + COUNT_BITS'(1);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    do_idle = 1'b1;
                end
                ST_START_LEAD: begin
                    if (b[7]) begin
                        type_next = stok_pkg::TYPE_WORD;
                        res[n_res] = stok_pkg::res_byte(type_next, lead_reg);
                        n_res = n_res + 2'd1;
                        res[n_res] = stok_pkg::res_byte(type_next, b);
                        n_res = n_res + 2'd1;
                        state_next = ST_WORD;
                    end else begin
                        res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_BAD_START);
                        n_res = n_res + 2'd1;
                        state_next = ST_FAILED;
                    end
                end
                ST_WORD: begin
                    do_word = 1'b1;
                end
                ST_WORD_LEAD: begin
                    if (b[7]) begin
                        res[n_res] = stok_pkg::res_byte(type_reg, lead_reg);
                        n_res = n_res + 2'd1;
                        res[n_res] = stok_pkg::res_byte(type_reg, b);
                        n_res = n_res + 2'd1;
                        state_next = ST_WORD;
                    end else begin
                        res[n_res] = stok_pkg::res_end(type_reg);
                        n_res = n_res + 2'd1;
                        res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_BAD_START);
                        n_res = n_res + 2'd1;
                        state_next = ST_FAILED;
                    end
                end
                ST_WORD_ESC: begin
                    if (b[7]) begin
                        lead_next  = b;
                        state_next = ST_WORD_ESC_LEAD;
                    end else begin
                        res[n_res] = stok_pkg::res_byte(type_reg, b);
                        n_res = n_res + 2'd1;
                        state_next = ST_WORD;
                    end
                end
                ST_WORD_ESC_LEAD: begin
                    res[n_res] = stok_pkg::res_byte(type_reg, lead_reg);
                    n_res = n_res + 2'd1;
                    state_next = ST_WORD;
                    if (b[7]) begin
                        res[n_res] = stok_pkg::res_byte(type_reg, b);
                        n_res = n_res + 2'd1;
                    end else begin
                        do_word = 1'b1;
                    end
                end
                ST_DOLLAR_TRIM: begin
                    if (!stok_pkg::is_space(b)) begin
                        state_next = ST_WORD;
                        do_word    = 1'b1;
                    end
                end
                ST_QUOTE: begin
                    priority if (b == qc) begin
                        if (keep_quotes_reg) begin
                            res[n_res] = stok_pkg::res_byte(type_reg, b);
                            n_res = n_res + 2'd1;
                        end
                        res[n_res] = stok_pkg::res_end(type_reg);
                        n_res = n_res + 2'd1;
                        state_next = ST_IDLE;
                    end else if (b == stok_pkg::CH_BSLASH) begin
                        state_next = ST_QUOTE_ESC;
                    end else if (stok_pkg::is_print(b)) begin
                        res[n_res] = stok_pkg::res_byte(type_reg, b);
                        n_res = n_res + 2'd1;
                    end else begin
                        res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_NONPRINT);
                        n_res = n_res + 2'd1;
                        state_next = ST_FAILED;
                    end
                end
                ST_QUOTE_ESC: begin
                    res[n_res] = stok_pkg::res_byte(type_reg, b);
                    n_res = n_res + 2'd1;
                    state_next = ST_QUOTE;
                end
                ST_FAILED: begin
                end
                default: begin
                    state_next = ST_IDLE;
                    do_idle    = 1'b1;
                end
            endcase

            // token start between tokens
            if (do_idle) begin
                priority if (stok_pkg::is_space(b)) begin
                end else if (b == stok_pkg::CH_DQUOTE || b == stok_pkg::CH_SQUOTE) begin
                    qsingle_next = (b == stok_pkg::CH_SQUOTE);
                    type_next    = qsingle_next ? stok_pkg::TYPE_SQUOTE
                                                : stok_pkg::TYPE_DQUOTE;
                    state_next   = ST_QUOTE;
                    if (keep_quotes_reg) begin
                        res[n_res] = stok_pkg::res_byte(type_next, b);
                        n_res = n_res + 2'd1;
                    end
                end else if (b == stok_pkg::CH_DOLLAR) begin
                    type_next  = stok_pkg::TYPE_LITERAL;
                    state_next = ST_DOLLAR_TRIM;
                end else if (stok_pkg::is_graph(b)) begin
                    type_next  = stok_pkg::TYPE_WORD;
                    state_next = ST_WORD;
                    do_word    = 1'b1;
                end else if (b[7]) begin
                    lead_next  = b;
                    state_next = ST_START_LEAD;
                end else begin
                    res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_BAD_START);
                    n_res = n_res + 2'd1;
                    state_next = ST_FAILED;
                end
            end

            // one byte inside a word or literal
            if (do_word) begin
                priority if (word_escapes_reg && b == stok_pkg::CH_BSLASH) begin
                    state_next = ST_WORD_ESC;
                end else if (stok_pkg::is_graph(b)) begin
                    res[n_res] = stok_pkg::res_byte(type_next, b);
                    n_res = n_res + 2'd1;
                end else if (b[7]) begin
                    lead_next  = b;
                    state_next = ST_WORD_LEAD;
                end else if (stok_pkg::is_space(b)) begin
                    res[n_res] = stok_pkg::res_end(type_next);
                    n_res = n_res + 2'd1;
                    state_next = ST_IDLE;
                end else begin
                    res[n_res] = stok_pkg::res_end(type_next);
                    n_res = n_res + 2'd1;
                    res[n_res] = stok_pkg::res_err(stok_pkg::CAUSE_BAD_START);
                    n_res = n_res + 2'd1;
                    state_next = ST_FAILED;
                end
            end
        end

        // mark the final result of this transfer
        for (int i = 0; i < 3; i++) begin
            res[i].last = (2'(i) == n_res - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_quotes_reg  <= 1'b0;
            word_escapes_reg <= 1'b0;
            state_reg        <= ST_IDLE;
            qsingle_reg      <= 1'b0;
            lead_reg         <= '0;
            type_reg         <= stok_pkg::TYPE_WORD;
            count_reg        <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_KEEP_QUOTES) begin
                    keep_quotes_reg <= cfg_wdata;
                end
                if (cfg_index == CFG_WORD_ESCAPES) begin
                    word_escapes_reg <= cfg_wdata;
                end
            end
            if (accept) begin
                state_reg   <= state_next;
                qsingle_reg <= qsingle_next;
                lead_reg    <= lead_next;
                type_reg    <= type_next;
                count_reg   <= count_next;
                tail_reg    <= tail_reg + n_res;
            end
            if (pop) begin
                head_reg <= head_reg + 2'd1;
            end
            fill_reg <= fill_reg + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
        end
    end

    // result queue payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_res) begin
                    q_reg[tail_reg + 2'(i)] <= res[i];
                end
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 3'd4)
        else $error("result queue overfilled");

    a_done_pushed: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_axis_tuser |=> fill_reg != 3'd0)
        else $error("end of text produced no status");

    a_failed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FAILED && !(accept && s_axis_tuser) |=> state_reg == ST_FAILED)
        else $error("left error state before end of text");

    a_idle_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_axis_tuser |=> state_reg == ST_IDLE && count_reg == '0)
        else $error("state not cleared after end of text");

endmodule

// ===== bench/shell_line_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// Shell line tokenizer testbench
// Streams short command lines, some well formed and some broken, through the
// tokenizer under every option setting. It predicts the token bytes, end
// markers, errors and done status that each accepted transfer should produce,
// and checks each result transfer against them in order. The sender works in
// random bursts. The receiver stalls at random and holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_tb;

    localparam int HALF_PERIOD        = 5;
    localparam int RESET_CYCLES       = 9;
    localparam int SETTLE_CYCLES      = 8;
    localparam int END_CYCLES         = 20;
    localparam int HOLD_OFF_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int RANDOM_PHASES      = 6;
    localparam int RANDOM_PHASE_ITEMS = 60;
    localparam int MAX_REPORTS        = 10;

    localparam logic REG_KEEP_QUOTES  = 1'b0;
    localparam logic REG_WORD_ESCAPES = 1'b1;

    // bit 8 marks end of text, bits 7:0 carry the text byte
    localparam logic [8:0] END_OF_TEXT = 9'h100;
    localparam int N_DIRECTED = 29;
    localparam logic [8:0] DIRECTED_TEXT [N_DIRECTED] = '{
        // escaped quote inside a double-quoted token
        9'h022, 9'h05C, 9'h022, 9'h022, END_OF_TEXT,
        // empty literal
        9'h024, 9'h009, END_OF_TEXT,
        // backslash at end of text in a word
        9'h061, 9'h05C, END_OF_TEXT,
        // backslash at end of text in quotes
        9'h027, 9'h05C, END_OF_TEXT,
        // escaped high byte standing alone
        9'h05C, 9'h0C1, 9'h07A, END_OF_TEXT,
        // pair, then a lone high byte; later bytes are dropped
        9'h0B0, 9'h0A1, 9'h0C8, 9'h000, 9'h0FF, END_OF_TEXT,
        // control byte inside quotes
        9'h027, 9'h001, END_OF_TEXT,
        // bad start byte
        9'h07F, END_OF_TEXT
    };

    typedef enum logic [3:0] {
        PM_IDLE, PM_LEAD_AT_START, PM_WORD, PM_WORD_LEAD, PM_WORD_ESC,
        PM_WORD_ESC_LEAD, PM_DOLLAR_SKIP, PM_QUOTED, PM_QUOTED_ESC, PM_FAILED
    } parse_mode_t;

    typedef struct {
        logic [7:0] text_byte;
        logic       eot;
    } text_item_t;

    class token_scoreboard;
        stok_pkg::result_t expected_q[$];
        int          mismatches;
        logic        quotes_kept;
        logic        escapes_in_words;
        parse_mode_t mode;
        logic        quote_single;
        logic [7:0]  lead_held;
        logic [1:0]  tok_type;
        logic [15:0] text_bytes;

        function new();
            mismatches = 0;
            quotes_kept = 1'b0;
            escapes_in_words = 1'b0;
            clear_text();
        endfunction

        function void clear_text();
            mode = PM_IDLE;
            quote_single = 1'b0;
            lead_held = '0;
            tok_type = stok_pkg::TYPE_WORD;
            text_bytes = '0;
        endfunction

        function void set_option(logic idx, logic val);
            if (idx == REG_KEEP_QUOTES) quotes_kept = val;
            else escapes_in_words = val;
        endfunction

        static function logic blank_byte(logic [7:0] b);
            return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        static function logic visible_byte(logic [7:0] b);
            return b >= 8'h21 && b <= 8'h7E;
        endfunction

        function void queue_result(logic [1:0] kind, logic [1:0] ttype, logic [7:0] b,
                                   logic [1:0] cause, logic ok, logic [15:0] cons);
            stok_pkg::result_t r;
            r = '0;
            r.kind = kind;
            r.token_type = ttype;
            r.out_byte = b;
            r.error_cause = cause;
            r.ok = ok;
            r.consumed = cons;
            expected_q.push_back(r);
        endfunction

        function void emit(logic [7:0] b);
            queue_result(stok_pkg::KIND_BYTE, tok_type, b, '0, 1'b0, '0);
        endfunction

        function void close_token();
            queue_result(stok_pkg::KIND_END, tok_type, '0, '0, 1'b0, '0);
        endfunction

        function void raise_error(logic [1:0] cause);
            queue_result(stok_pkg::KIND_ERR, '0, '0, cause, 1'b0, '0);
            mode = PM_FAILED;
        endfunction

        function void word_step(logic [7:0] b);
            if (escapes_in_words && b == stok_pkg::CH_BSLASH) begin
                mode = PM_WORD_ESC;
            end else if (visible_byte(b)) begin
                emit(b);
            end else if (b[7]) begin
                lead_held = b;
                mode = PM_WORD_LEAD;
            end else if (blank_byte(b)) begin
                close_token();
                mode = PM_IDLE;
            end else begin
                close_token();
                raise_error(stok_pkg::CAUSE_BAD_START);
            end
        endfunction

        function void idle_step(logic [7:0] b);
            if (blank_byte(b)) begin
                // skip separators
            end else if (b == stok_pkg::CH_DQUOTE || b == stok_pkg::CH_SQUOTE) begin
                quote_single = (b == stok_pkg::CH_SQUOTE);
                tok_type = quote_single ? stok_pkg::TYPE_SQUOTE : stok_pkg::TYPE_DQUOTE;
                mode = PM_QUOTED;
                if (quotes_kept) emit(b);
            end else if (b == stok_pkg::CH_DOLLAR) begin
                tok_type = stok_pkg::TYPE_LITERAL;
                mode = PM_DOLLAR_SKIP;
            end else if (visible_byte(b)) begin
                tok_type = stok_pkg::TYPE_WORD;
                mode = PM_WORD;
                word_step(b);
            end else if (b[7]) begin
                lead_held = b;
                mode = PM_LEAD_AT_START;
            end else begin
                raise_error(stok_pkg::CAUSE_BAD_START);
            end
        endfunction

        function void byte_step(logic [7:0] b);
            logic [7:0] closing;
            closing = quote_single ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE;
            case (mode)
                PM_IDLE: idle_step(b);
                PM_LEAD_AT_START: begin
                    if (b[7]) begin
                        tok_type = stok_pkg::TYPE_WORD;
                        emit(lead_held);
                        emit(b);
                        mode = PM_WORD;
                    end else begin
                        raise_error(stok_pkg::CAUSE_BAD_START);
                    end
                end
                PM_WORD: word_step(b);
                PM_WORD_LEAD: begin
                    if (b[7]) begin
                        emit(lead_held);
                        emit(b);
                        mode = PM_WORD;
                    end else begin
                        close_token();
                        raise_error(stok_pkg::CAUSE_BAD_START);
                    end
                end
                PM_WORD_ESC: begin
                    if (b[7]) begin
                        lead_held = b;
                        mode = PM_WORD_ESC_LEAD;
                    end else begin
                        emit(b);
                        mode = PM_WORD;
                    end
                end
                PM_WORD_ESC_LEAD: begin
                    emit(lead_held);
                    mode = PM_WORD;
                    if (b[7]) emit(b);
                    else word_step(b);
                end
                PM_DOLLAR_SKIP: begin
                    if (!blank_byte(b)) begin
                        mode = PM_WORD;
                        word_step(b);
                    end
                end
                PM_QUOTED: begin
                    if (b == closing) begin
                        if (quotes_kept) emit(b);
                        close_token();
                        mode = PM_IDLE;
                    end else if (b == stok_pkg::CH_BSLASH) begin
                        mode = PM_QUOTED_ESC;
                    end else if (b >= 8'h20 && b <= 8'h7E) begin
                        emit(b);
                    end else begin
                        raise_error(stok_pkg::CAUSE_NONPRINT);
                    end
                end
                PM_QUOTED_ESC: begin
                    emit(b);
                    mode = PM_QUOTED;
                end
                default: ;
            endcase
        endfunction

        function void text_end_step();
            case (mode)
                PM_LEAD_AT_START: raise_error(stok_pkg::CAUSE_BAD_START);
                PM_WORD, PM_WORD_ESC, PM_DOLLAR_SKIP: close_token();
                PM_WORD_LEAD: begin
                    close_token();
                    raise_error(stok_pkg::CAUSE_BAD_START);
                end
                PM_WORD_ESC_LEAD: begin
                    emit(lead_held);
                    close_token();
                end
                PM_QUOTED, PM_QUOTED_ESC: raise_error(stok_pkg::CAUSE_UNTERM);
                default: ;
            endcase
            if (mode == PM_FAILED)
                queue_result(stok_pkg::KIND_DONE, '0, '0, '0, 1'b0, '0);
            else
                queue_result(stok_pkg::KIND_DONE, '0, '0, '0, 1'b1, text_bytes);
            clear_text();
        endfunction

        function void note_input(logic [7:0] b, logic eot);
            int before_n;
            before_n = expected_q.size();
            if (eot) begin
                text_end_step();
            end else begin
                if (text_bytes != stok_pkg::CONS_MAX) text_bytes++;
                byte_step(b);
            end
            if (expected_q.size() > before_n) expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] data, logic last);
            stok_pkg::result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result kind %0d data %08h last %0d",
                             $time, kind, data, last);
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind || data[1:0] !== want.token_type ||
                data[9:2] !== want.out_byte || data[11:10] !== want.error_cause ||
                data[12] !== want.ok || data[28:13] !== want.consumed ||
                data[31:29] !== 3'b000 || last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch expected kind %0d type %0d byte %02h cause %0d",
                             $time, want.kind, want.token_type, want.out_byte,
                             want.error_cause);
                    $display("    ok %0d consumed %0d last %0d", want.ok, want.consumed,
                             want.last);
                    $display("  got kind %0d type %0d byte %02h cause %0d ok %0d",
                             kind, data[1:0], data[9:2], data[11:10], data[12]);
                    $display("    consumed %0d pad %0d last %0d", data[28:13],
                             data[31:29], last);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    token_scoreboard sb;
    text_item_t      text_q[$];
    logic            hold_off_req = 1'b0;
    int              quiet_cycles = 0;

    shell_line_tokenizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Track transfers on both sides and guard against a hung block.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tdata, s_axis_tuser);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: ready stretches, random stalls, and one long hold-off on request.
    initial begin : receiver_pattern
        int  seg_kind;
        int  seg_len;
        bit  hold_off_done;
        hold_off_done = 1'b0;
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                seg_kind = $urandom_range(0, 2);
                seg_len = $urandom_range(8, 48);
                repeat (seg_len) begin
                    case (seg_kind)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                        default: m_axis_tready <= ($urandom_range(0, 2) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    function automatic void put_text_byte(logic [7:0] b);
        text_item_t it;
        it.text_byte = b;
        it.eot = 1'b0;
        text_q.push_back(it);
    endfunction

    function automatic void put_text_end();
        text_item_t it;
        it.text_byte = 8'($urandom);
        it.eot = 1'b1;
        text_q.push_back(it);
    endfunction

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(8'h09 + k);
    endfunction

    function automatic logic [7:0] pick_visible();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] pick_high();
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    function automatic void add_word(int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    put_text_byte(pick_high());
                    put_text_byte(pick_high());
                end
                1: begin
                    put_text_byte(stok_pkg::CH_BSLASH);
                    put_text_byte(($urandom_range(0, 3) == 0) ? pick_high() : pick_visible());
                end
                default: begin
                    c = pick_visible();
                    // keep the token a word
                    if (i == 0 && (c == stok_pkg::CH_DQUOTE || c == stok_pkg::CH_SQUOTE ||
                                   c == stok_pkg::CH_DOLLAR))
                        c = 8'h41;
                    put_text_byte(c);
                end
            endcase
        end
    endfunction

    function automatic void add_quoted(bit closed);
        logic [7:0] q;
        logic [7:0] c;
        int         len;
        q = $urandom_range(0, 1) ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE;
        len = $urandom_range(0, 6);
        put_text_byte(q);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                put_text_byte(stok_pkg::CH_BSLASH);
                put_text_byte(8'($urandom));
            end else begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == q || c == stok_pkg::CH_BSLASH) c = 8'h20;
                put_text_byte(c);
            end
        end
        if (closed) put_text_byte(q);
    endfunction

    function automatic void add_random_text();
        int ntok;
        ntok = $urandom_range(0, 4);
        for (int i = 0; i < ntok; i++) begin
            if (i > 0 || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) put_text_byte(pick_blank());
            case ($urandom_range(0, 2))
                0: add_word($urandom_range(1, 6));
                1: begin
                    put_text_byte(stok_pkg::CH_DOLLAR);
                    repeat ($urandom_range(0, 2)) put_text_byte(pick_blank());
                    add_word($urandom_range(0, 4));
                end
                default: add_quoted(1'b1);
            endcase
        end
        case ($urandom_range(0, 11))
            0: repeat ($urandom_range(1, 3)) put_text_byte(8'($urandom));
            1: add_quoted(1'b0);
            2: put_text_byte(stok_pkg::CH_BSLASH);
            3: put_text_byte(pick_high());
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) put_text_byte(pick_blank());
        put_text_end();
    endfunction

    task automatic push_item(input logic [7:0] b, input logic eot);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= eot;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic drive_text_queue();
        text_item_t it;
        int         burst_left;
        int         gap;
        burst_left = $urandom_range(1, 24);
        while (text_q.size() > 0) begin
            it = text_q.pop_front();
            push_item(it.text_byte, it.eot);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_config(input logic keep, input logic esc);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_KEEP_QUOTES;
        cfg_wdata <= keep;
        sb.set_option(REG_KEEP_QUOTES, keep);
        @(posedge aclk);
        cfg_index <= REG_WORD_ESCAPES;
        cfg_wdata <= esc;
        sb.set_option(REG_WORD_ESCAPES, esc);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        // bytes that yield nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : main_sequence
        logic keep;
        logic esc;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_config(1'b1, 1'b1);
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED_TEXT[i][8]) put_text_end();
            else put_text_byte(DIRECTED_TEXT[i][7:0]);
        end
        drive_text_queue();
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            keep = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
            esc = (p < 4) ? p[1] : 1'($urandom_range(0, 1));
            write_config(keep, esc);
            if (p == 1) hold_off_req = 1'b1;
            while (text_q.size() < RANDOM_PHASE_ITEMS) add_random_text();
            drive_text_queue();
            wait_idle();
        end

        repeat (END_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/stok_pkg.sv
sv/shell_line_tokenizer.sv
bench/shell_line_tokenizer_tb.sv
